>>> hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and types for the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueW   = 9;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ProdW  = 14;  // v*s, up to 10000
  localparam int unsigned CompW  = 20;  // component at scale 1/600000
  localparam int unsigned ScaledW = 28; // 255*n + half scale
  localparam int unsigned RecipW = 29;
  localparam int unsigned ShiftBits = 48;
  localparam int unsigned QuotW  = ScaledW + RecipW;

  localparam logic [PctW-1:0]  PctMax   = 7'd100;
  localparam logic [HueW-1:0]  HueLimit = 9'd360;

  localparam logic [63:0] Scale    = 64'd600000;
  localparam logic [63:0] RecipFull = ((64'd1 << ShiftBits) + Scale - 64'd1) / Scale;
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];
  localparam logic [ScaledW-1:0] HalfScale = ScaledW'(Scale / 64'd2);
  localparam logic [ScaledW-1:0] ChanMax = 28'd255;

  typedef enum logic [2:0] {
    SecRedYel  = 3'd0,
    SecYelGrn  = 3'd1,
    SecGrnCyan = 3'd2,
    SecCyanBlu = 3'd3,
    SecBluMag  = 3'd4,
    SecMagRed  = 3'd5
  } sector_e;

endpackage

`default_nettype wire

>>> hdl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts hue (degrees), saturation and value (percent) to 8-bit RGB.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock, busy_o is always low and the result
// appears with done_o after the request has passed all four stages, which
// are: clamp and sector decode with v*s; chroma, secondary and offset
// products; offset add and 255 scaling; reciprocal multiply for the division.
// The receiver cannot stall the pipeline. Hue of 360 or more returns black.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [hsv2rgb_pkg::HueW-1:0]  hue_deg_i,
  input  wire logic [hsv2rgb_pkg::PctW-1:0]  sat_pct_i,
  input  wire logic [hsv2rgb_pkg::PctW-1:0]  val_pct_i,
  output logic                               done_o,
  output logic      [hsv2rgb_pkg::ChanW-1:0] red_o,
  output logic      [hsv2rgb_pkg::ChanW-1:0] green_o,
  output logic      [hsv2rgb_pkg::ChanW-1:0] blue_o
);
  import hsv2rgb_pkg::*;

  // stage 1
  logic [PctW-1:0]  sat_c, val_c;
  logic [HueW-1:0]  hue_base, hue_rem;
  logic [5:0]       frac;
  sector_e          sec;
  logic [ProdW-1:0] vs_d, vs_q, vm_d, vm_q;
  logic [5:0]       frac_q;
  sector_e          sec1_q;
  logic             blank1_q;

  // stage 2
  logic [CompW-1:0] chroma_q, second_q, ofs_q;
  sector_e          sec2_q;
  logic             blank2_q;
  logic [CompW-1:0] comp_r, comp_g, comp_b, ofs;

  logic [3:0] vld_q;
  logic       req;

  assign busy_o = 1'b0;
  assign req    = start_i & ~busy_o;

  assign sat_c = (sat_pct_i > PctMax) ? PctMax : sat_pct_i;
  assign val_c = (val_pct_i > PctMax) ? PctMax : val_pct_i;

  always_comb begin
    if (hue_deg_i < 9'd60) begin
      sec = SecRedYel;
    end else if (hue_deg_i < 9'd120) begin
      sec = SecYelGrn;
    end else if (hue_deg_i < 9'd180) begin
      sec = SecGrnCyan;
    end else if (hue_deg_i < 9'd240) begin
      sec = SecCyanBlu;
    end else if (hue_deg_i < 9'd300) begin
      sec = SecBluMag;
    end else begin
      sec = SecMagRed;
    end
  end

  always_comb begin
    case (sec)
      SecRedYel, SecYelGrn:  hue_base = 9'd0;
      SecGrnCyan, SecCyanBlu: hue_base = 9'd120;
      default:               hue_base = 9'd240;
    endcase
  end

  assign hue_rem = hue_deg_i - hue_base;
  assign frac    = (hue_rem >= 9'd60) ? 6'(9'd120 - hue_rem) : hue_rem[5:0];
  assign vs_d    = ProdW'(val_c) * ProdW'(sat_c);
  assign vm_d    = ProdW'(val_c) * ProdW'(PctMax - sat_c);

  always_ff @(posedge clk_i) begin
    vs_q     <= vs_d;
    vm_q     <= vm_d;
    frac_q   <= frac;
    sec1_q   <= sec;
    blank1_q <= (hue_deg_i >= HueLimit);
    chroma_q <= CompW'(vs_q) * CompW'(60);
    second_q <= CompW'(vs_q) * CompW'(frac_q);
    ofs_q    <= CompW'(vm_q) * CompW'(60);
    sec2_q   <= sec1_q;
    blank2_q <= blank1_q;
  end

  always_comb begin
    comp_r = '0;
    comp_g = '0;
    comp_b = '0;
    case (sec2_q)
      SecRedYel: begin
        comp_r = chroma_q;
        comp_g = second_q;
      end
      SecYelGrn: begin
        comp_r = second_q;
        comp_g = chroma_q;
      end
      SecGrnCyan: begin
        comp_g = chroma_q;
        comp_b = second_q;
      end
      SecCyanBlu: begin
        comp_g = second_q;
        comp_b = chroma_q;
      end
      SecBluMag: begin
        comp_r = second_q;
        comp_b = chroma_q;
      end
      default: begin
        comp_r = chroma_q;
        comp_b = second_q;
      end
    endcase
    ofs = ofs_q;
    if (blank2_q) begin
      comp_r = '0;
      comp_g = '0;
      comp_b = '0;
      ofs    = '0;
    end
  end

  hsv2rgb_chan u_chan_r (
    .clk_i  (clk_i),
    .comp_i (comp_r),
    .ofs_i  (ofs),
    .chan_o (red_o)
  );

  hsv2rgb_chan u_chan_g (
    .clk_i  (clk_i),
    .comp_i (comp_g),
    .ofs_i  (ofs),
    .chan_o (green_o)
  );

  hsv2rgb_chan u_chan_b (
    .clk_i  (clk_i),
    .comp_i (comp_b),
    .ofs_i  (ofs),
    .chan_o (blue_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req};
    end
  end

  assign done_o = vld_q[3];

endmodule

`default_nettype wire

>>> hdl/hsv2rgb_chan.sv
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// One output channel: adds the offset, scales by 255 with rounding and
// divides by the fixed-point scale through a reciprocal multiply.
// Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_chan (
  input  wire logic                          clk_i,
  input  wire logic [hsv2rgb_pkg::CompW-1:0] comp_i,
  input  wire logic [hsv2rgb_pkg::CompW-1:0] ofs_i,
  output logic      [hsv2rgb_pkg::ChanW-1:0] chan_o
);
  import hsv2rgb_pkg::*;

  logic [CompW-1:0]   sum;
  logic [ScaledW-1:0] scaled_d, scaled_q;
  logic [QuotW-1:0]   prod_d, prod_q;

  assign sum      = comp_i + ofs_i;
  assign scaled_d = ScaledW'(sum) * ChanMax + HalfScale;
  assign prod_d   = QuotW'(scaled_q) * QuotW'(Recip);

  always_ff @(posedge clk_i) begin
    scaled_q <= scaled_d;
    prod_q   <= prod_d;
  end

  assign chan_o = prod_q[ShiftBits +: ChanW];

endmodule

`default_nettype wire

>>> tb/sv/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking bench for the HSV to RGB converter. A short table of directed
// requests covers the six hue sectors, black and white, clamped saturation and
// value, out-of-range hue and a rounding half. Random requests follow in
// phases with and without sender gaps. Every result is compared per channel
// against the table color or a fixed-point color model kept here.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
  import hsv2rgb_pkg::*;

  localparam int unsigned FullScale   = 600000;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandPerPhase = 232;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    bit              typed;
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
    rgb_t            rgb;
  } hsv_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic [HueW-1:0]  hue_deg_i = '0;
  logic [PctW-1:0]  sat_pct_i = '0;
  logic [PctW-1:0]  val_pct_i = '0;
  logic             busy_o;
  logic             done_o;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  rgb_t        staged_rgb = '0;
  rgb_t        rgb_due_q[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // typed rows carry their expected color, the rest go through convert_hsv
  hsv_row_t directed_rows [24] = '{
    '{1'b1, 9'd0,   7'd100, 7'd100, '{8'd255, 8'd0,   8'd0  }},
    '{1'b1, 9'd120, 7'd100, 7'd100, '{8'd0,   8'd255, 8'd0  }},
    '{1'b1, 9'd240, 7'd100, 7'd100, '{8'd0,   8'd0,   8'd255}},
    '{1'b1, 9'd60,  7'd100, 7'd100, '{8'd255, 8'd255, 8'd0  }},
    '{1'b1, 9'd180, 7'd100, 7'd100, '{8'd0,   8'd255, 8'd255}},
    '{1'b1, 9'd300, 7'd100, 7'd100, '{8'd255, 8'd0,   8'd255}},
    '{1'b1, 9'd77,  7'd0,   7'd100, '{8'd255, 8'd255, 8'd255}},
    '{1'b1, 9'd200, 7'd100, 7'd0,   '{8'd0,   8'd0,   8'd0  }},
    '{1'b1, 9'd360, 7'd100, 7'd100, '{8'd0,   8'd0,   8'd0  }},
    '{1'b1, 9'd511, 7'd127, 7'd127, '{8'd0,   8'd0,   8'd0  }},
    '{1'b1, 9'd0,   7'd127, 7'd127, '{8'd255, 8'd0,   8'd0  }},
    '{1'b1, 9'd0,   7'd0,   7'd50,  '{8'd128, 8'd128, 8'd128}},
    '{1'b0, 9'd359, 7'd100, 7'd100, '0},
    '{1'b0, 9'd59,  7'd100, 7'd100, '0},
    '{1'b0, 9'd61,  7'd80,  7'd90,  '0},
    '{1'b0, 9'd119, 7'd50,  7'd100, '0},
    '{1'b0, 9'd121, 7'd101, 7'd55,  '0},
    '{1'b0, 9'd239, 7'd37,  7'd101, '0},
    '{1'b0, 9'd299, 7'd127, 7'd64,  '0},
    '{1'b0, 9'd330, 7'd1,   7'd1,   '0},
    '{1'b0, 9'd90,  7'd100, 7'd1,   '0},
    '{1'b0, 9'd255, 7'd63,  7'd127, '0},
    '{1'b0, 9'd45,  7'd64,  7'd32,  '0},
    '{1'b0, 9'd270, 7'd99,  7'd99,  '0}
  };

  int unsigned idle_plan [4] = '{0, 62, 32, 0};

  hsv_to_rgb_converter dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .hue_deg_i (hue_deg_i),
    .sat_pct_i (sat_pct_i),
    .val_pct_i (val_pct_i),
    .done_o    (done_o),
    .red_o     (red_o),
    .green_o   (green_o),
    .blue_o    (blue_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ChanW-1:0] scale_to_8bit(int unsigned n);
    return ChanW'((255 * n + FullScale / 2) / FullScale);
  endfunction

  function automatic rgb_t convert_hsv(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                                       logic [PctW-1:0] val);
    int unsigned s, v, r, f, c, x, m, pr, pg, pb;
    rgb_t rgb;
    rgb = '0;
    if (hue >= HueLimit) begin
      return rgb;
    end
    s = (sat > PctMax) ? PctMax : sat;
    v = (val > PctMax) ? PctMax : val;
    r = hue % 120;
    f = (r >= 60) ? (120 - r) : r;
    c = v * s * 60;
    x = v * s * f;
    m = v * (100 - s) * 60;
    case (sector_e'(hue / 60))
      SecRedYel: begin
        pr = c; pg = x; pb = 0;
      end
      SecYelGrn: begin
        pr = x; pg = c; pb = 0;
      end
      SecGrnCyan: begin
        pr = 0; pg = c; pb = x;
      end
      SecCyanBlu: begin
        pr = 0; pg = x; pb = c;
      end
      SecBluMag: begin
        pr = x; pg = 0; pb = c;
      end
      default: begin
        pr = c; pg = 0; pb = x;
      end
    endcase
    rgb.red   = scale_to_8bit(pr + m);
    rgb.green = scale_to_8bit(pg + m);
    rgb.blue  = scale_to_8bit(pb + m);
    return rgb;
  endfunction

  // gaps of random length, junk on the fields while start is low
  task automatic issue_request(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                               logic [PctW-1:0] val, rgb_t due, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i   <= 1'b0;
      hue_deg_i <= HueW'($urandom);
      sat_pct_i <= PctW'($urandom);
      val_pct_i <= PctW'($urandom);
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    hue_deg_i  <= hue;
    sat_pct_i  <= sat;
    val_pct_i  <= val;
    staged_rgb <= due;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
  endtask

  // wait on the clock before the first check, so the last request is already queued
  task automatic drain_results();
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (rgb_due_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    rgb_t due;
    if (rst_ni && start_i && !busy_o) begin
      rgb_due_q.push_back(staged_rgb);
    end
    if (rst_ni && done_o) begin
      if (rgb_due_q.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", red_o, green_o, blue_o);
        mismatch_count++;
      end else begin
        due = rgb_due_q.pop_front();
        if (red_o !== due.red) begin
          $error("red: expected %0d, got %0d", due.red, red_o);
          mismatch_count++;
        end
        if (green_o !== due.green) begin
          $error("green: expected %0d, got %0d", due.green, green_o);
          mismatch_count++;
        end
        if (blue_o !== due.blue) begin
          $error("blue: expected %0d, got %0d", due.blue, blue_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
    rgb_t due;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      due = directed_rows[i].typed ? directed_rows[i].rgb :
            convert_hsv(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].val);
      issue_request(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].val, due, 0);
    end
    drain_results();

    foreach (idle_plan[p]) begin
      for (int unsigned n = 0; n < RandPerPhase; n++) begin
        // mostly meaningful colors, some out-of-range hue and clamped percents
        if ($urandom_range(99) < 15) begin
          hue = HueW'($urandom);
        end else if ($urandom_range(99) < 10) begin
          hue = HueW'(60 * $urandom_range(5) + $urandom_range(2)) - HueW'(1);
          if (hue >= HueLimit) hue = '0;
        end else begin
          hue = HueW'($urandom_range(359));
        end
        sat = ($urandom_range(99) < 20) ? PctW'($urandom) : PctW'($urandom_range(100));
        val = ($urandom_range(99) < 20) ? PctW'($urandom) : PctW'($urandom_range(100));
        issue_request(hue, sat, val, convert_hsv(hue, sat, val), idle_plan[p]);
      end
      drain_results();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && rgb_due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> hsv_to_rgb_converter.f
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_chan.sv
hdl/hsv_to_rgb_converter.sv
tb/sv/hsv_to_rgb_converter_tb.sv
